@@ hdl/lhfr_pkg.sv @@
// shared types and constants for the love/hate frame replacer
`timescale 1ns / 1ps

package lhfr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int PIN_MAX    = 255;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PIN_W      = $clog2(PIN_MAX + 1);
  localparam int ACTION_W   = 3;
  localparam int FRAME_W    = 4;
  localparam int STATUS_W   = 2;

  // action codes of the input transfer
  localparam logic [ACTION_W-1:0] ACT_PIN_HIT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNPIN     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_VICTIM    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_FLUSH_ALL = 3'd5;

  // status codes of the result transfer
  localparam logic [STATUS_W-1:0] ST_OK             = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNPIN_UNPINNED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_PINNED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_VICTIM      = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PIN_HIT = 3'd1,
    OP_LOAD    = 3'd2,
    OP_UNPIN   = 3'd3,
    OP_FREE    = 3'd4,
    OP_FLUSH   = 3'd5
  } frame_op_t;

  typedef struct packed {
    frame_op_t        op;
    logic [IDX_W-1:0] addr;
    logic             hate;
  } frame_cmd_t;

endpackage

@@ hdl/love_hate_frame_replacer_core.sv @@
// top level: action sequencer walking the recency list one slot per cycle
// path from accept to out_valid: unpin, free and flush_all go through exec then resp, ignored items go
//   straight to resp, pin_hit and load add the move-to-front walk after exec, victim queries walk the list
// throughput: one item at a time, in_stall high from accept until the result is loaded;
//   the next transfer may come with the result, pin_hit, load and victim wait on the single-port list walk
// reset: synchronous active-low rst_n clears pins, loved marks, list valid bits, control
`timescale 1ns / 1ps

module love_hate_frame_replacer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lhfr_pkg::ACTION_W-1:0] in_action,
  input  logic [lhfr_pkg::FRAME_W-1:0]  in_frame_index,
  input  logic                          in_hate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lhfr_pkg::STATUS_W-1:0] out_status,
  output logic [lhfr_pkg::FRAME_W-1:0]  out_victim_frame
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,  // pin / mark update
    S_TOUCH = 5'b00100,  // move-to-front walk
    S_VICT  = 5'b01000,  // victim search walk
    S_RESP  = 5'b10000   // result waits for the output register
  } state_t;

  localparam logic [lhfr_pkg::IDX_W-1:0] LAST_SLOT = lhfr_pkg::IDX_W'(lhfr_pkg::NUM_FRAMES - 1);

  state_t                          state_r, state_nxt;
  logic [lhfr_pkg::ACTION_W-1:0]   act_r, act_nxt;
  logic [lhfr_pkg::IDX_W-1:0]      frame_r, frame_nxt;
  logic                            hate_r, hate_nxt;
  logic [lhfr_pkg::IDX_W-1:0]      slot_r, slot_nxt;      // list walk position
  logic [lhfr_pkg::IDX_W-1:0]      carry_r, carry_nxt;    // frame being pushed down the list
  logic                            found_loved_r, found_loved_nxt;
  logic [lhfr_pkg::IDX_W-1:0]      loved_pick_r, loved_pick_nxt;
  logic [lhfr_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [lhfr_pkg::FRAME_W-1:0]    res_victim_r, res_victim_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lhfr_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [lhfr_pkg::FRAME_W-1:0]    out_victim_r, out_victim_nxt;

  lhfr_pkg::frame_cmd_t            cmd;
  logic [lhfr_pkg::IDX_W-1:0]      frame_rd_addr;
  logic                            rd_pin_zero;
  logic                            rd_loved;
  logic                            list_wr_en;
  logic [lhfr_pkg::IDX_W-1:0]      list_rd_frame;
  logic                            list_rd_valid;

  logic                            in_xfer;
  logic                            in_frame_ok;
  logic                            out_free;
  logic                            cand_hated;
  logic                            cand_loved;

  lhfr_frame_state u_frames (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (frame_rd_addr),
    .rd_pin_zero (rd_pin_zero),
    .rd_loved    (rd_loved)
  );

  lhfr_recency_list u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (slot_r),
    .wr_en    (list_wr_en),
    .wr_frame (carry_r),
    .rd_frame (list_rd_frame),
    .rd_valid (list_rd_valid)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // frame numbers past the pool size make actions 0..3 do nothing
  assign in_frame_ok = ({1'b0, in_frame_index} < (lhfr_pkg::FRAME_W + 1)'(lhfr_pkg::NUM_FRAMES));
  // output register can take a new result this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // during the victim walk the frame table is read at the candidate from the list
  assign frame_rd_addr = (state_r == S_VICT) ? list_rd_frame : frame_r;
  assign cand_hated    = list_rd_valid && rd_pin_zero && !rd_loved;
  assign cand_loved    = list_rd_valid && rd_pin_zero && rd_loved;

  assign list_wr_en = (state_r == S_TOUCH);

  // frame table update, issued only in the exec cycle
  always_comb begin
    cmd.op   = lhfr_pkg::OP_NONE;
    cmd.addr = frame_r;
    cmd.hate = hate_r;
    if (state_r == S_EXEC) begin
      unique case (act_r)
        lhfr_pkg::ACT_PIN_HIT:   cmd.op = lhfr_pkg::OP_PIN_HIT;
        lhfr_pkg::ACT_LOAD:      cmd.op = lhfr_pkg::OP_LOAD;
        lhfr_pkg::ACT_UNPIN:     cmd.op = lhfr_pkg::OP_UNPIN;
        lhfr_pkg::ACT_FREE:      cmd.op = lhfr_pkg::OP_FREE;
        lhfr_pkg::ACT_FLUSH_ALL: cmd.op = lhfr_pkg::OP_FLUSH;
        default:                 cmd.op = lhfr_pkg::OP_NONE;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    frame_nxt       = frame_r;
    hate_nxt        = hate_r;
    slot_nxt        = slot_r;
    carry_nxt       = carry_r;
    found_loved_nxt = found_loved_r;
    loved_pick_nxt  = loved_pick_r;
    res_status_nxt  = res_status_r;
    res_victim_nxt  = res_victim_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_victim_nxt  = out_victim_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt         = in_action;
          frame_nxt       = lhfr_pkg::IDX_W'(in_frame_index);
          hate_nxt        = in_hate;
          slot_nxt        = '0;
          carry_nxt       = lhfr_pkg::IDX_W'(in_frame_index);
          found_loved_nxt = 1'b0;
          loved_pick_nxt  = '0;
          res_status_nxt  = lhfr_pkg::ST_OK;
          res_victim_nxt  = '0;
          if (in_action == lhfr_pkg::ACT_VICTIM) begin
            state_nxt = S_VICT;
          end else if (in_action == lhfr_pkg::ACT_FLUSH_ALL) begin
            state_nxt = S_EXEC;
          end else if (in_action <= lhfr_pkg::ACT_FREE && in_frame_ok) begin
            state_nxt = S_EXEC;
          end else begin
            // out-of-range frame or unknown action: plain ok
            state_nxt = S_RESP;
          end
        end
      end

      S_EXEC: begin
        if (act_r == lhfr_pkg::ACT_UNPIN && rd_pin_zero) begin
          res_status_nxt = lhfr_pkg::ST_UNPIN_UNPINNED;
        end else if (act_r == lhfr_pkg::ACT_FREE && !rd_pin_zero) begin
          res_status_nxt = lhfr_pkg::ST_FREE_PINNED;
        end
        if (act_r == lhfr_pkg::ACT_PIN_HIT || act_r == lhfr_pkg::ACT_LOAD) begin
          state_nxt = S_TOUCH;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_TOUCH: begin
        // write the carried frame into this slot and pick up the old one;
        // stop at an empty slot, at the frame's old slot, or at the list end
        if (!list_rd_valid || list_rd_frame == frame_r || slot_r == LAST_SLOT) begin
          state_nxt = S_RESP;
        end else begin
          carry_nxt = list_rd_frame;
          slot_nxt  = slot_r + 1'b1;
        end
      end

      S_VICT: begin
        if (cand_hated) begin
          // most recent unpinned hated frame wins at once
          res_victim_nxt = lhfr_pkg::FRAME_W'(list_rd_frame);
          state_nxt      = S_RESP;
        end else begin
          if (cand_loved) begin
            found_loved_nxt = 1'b1;
            loved_pick_nxt  = list_rd_frame;
          end
          if (!list_rd_valid || slot_r == LAST_SLOT) begin
            if (found_loved_r || cand_loved) begin
              res_victim_nxt = lhfr_pkg::FRAME_W'(cand_loved ? list_rd_frame : loved_pick_r);
            end else begin
              res_status_nxt = lhfr_pkg::ST_NO_VICTIM;
            end
            state_nxt = S_RESP;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_victim_nxt = res_victim_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers, no reset needed
  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    frame_r       <= frame_nxt;
    hate_r        <= hate_nxt;
    slot_r        <= slot_nxt;
    carry_r       <= carry_nxt;
    found_loved_r <= found_loved_nxt;
    loved_pick_r  <= loved_pick_nxt;
    res_status_r  <= res_status_nxt;
    res_victim_r  <= res_victim_nxt;
    out_status_r  <= out_status_nxt;
    out_victim_r  <= out_victim_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_victim_frame = out_victim_r;

endmodule

@@ hdl/lhfr_frame_state.sv @@
// per-frame pin counts and loved marks with one read port and one update port
`timescale 1ns / 1ps

module lhfr_frame_state (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lhfr_pkg::frame_cmd_t     cmd,
  input  logic [lhfr_pkg::IDX_W-1:0] rd_addr,
  output logic                     rd_pin_zero,
  output logic                     rd_loved
);

  logic [lhfr_pkg::PIN_W-1:0] pin_r   [lhfr_pkg::NUM_FRAMES];
  logic [lhfr_pkg::NUM_FRAMES-1:0] loved_r;
  logic [lhfr_pkg::PIN_W-1:0] cur_pin;

  assign cur_pin     = pin_r[cmd.addr];
  assign rd_pin_zero = (pin_r[rd_addr] == '0);
  assign rd_loved    = loved_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lhfr_pkg::NUM_FRAMES; i++) begin
        pin_r[i] <= '0;
      end
      loved_r <= '0;
    end else begin
      unique case (cmd.op)
        lhfr_pkg::OP_PIN_HIT: begin
          if (cur_pin != lhfr_pkg::PIN_W'(lhfr_pkg::PIN_MAX)) begin
            pin_r[cmd.addr] <= cur_pin + 1'b1;
          end
        end
        lhfr_pkg::OP_LOAD: begin
          pin_r[cmd.addr]   <= lhfr_pkg::PIN_W'(1);
          loved_r[cmd.addr] <= 1'b0;
        end
        lhfr_pkg::OP_UNPIN: begin
          if (cur_pin != '0) begin
            pin_r[cmd.addr]   <= cur_pin - 1'b1;
            loved_r[cmd.addr] <= loved_r[cmd.addr] | ~cmd.hate;
          end
        end
        lhfr_pkg::OP_FREE: begin
          if (cur_pin == '0) begin
            loved_r[cmd.addr] <= 1'b0;
          end
        end
        lhfr_pkg::OP_FLUSH: begin
          for (int i = 0; i < lhfr_pkg::NUM_FRAMES; i++) begin
            pin_r[i] <= '0;
          end
          loved_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/lhfr_recency_list.sv @@
// recency list slots (frame numbers, most recent first) with per-slot valid bits
`timescale 1ns / 1ps

module lhfr_recency_list (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lhfr_pkg::IDX_W-1:0] idx,
  input  logic                       wr_en,
  input  logic [lhfr_pkg::IDX_W-1:0] wr_frame,
  output logic [lhfr_pkg::IDX_W-1:0] rd_frame,
  output logic                       rd_valid
);

  logic [lhfr_pkg::IDX_W-1:0]      order_r [lhfr_pkg::NUM_FRAMES];
  logic [lhfr_pkg::NUM_FRAMES-1:0] valid_r;

  assign rd_frame = order_r[idx];
  assign rd_valid = valid_r[idx];

  // slot contents are only read behind a set valid bit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      order_r[idx] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

endmodule

@@ hdl/lhfr_checker.sv @@
// port-level checker for the frame replacer and its bind to the top level
`timescale 1ns / 1ps

module lhfr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [lhfr_pkg::ACTION_W-1:0] in_action,
  input logic [lhfr_pkg::FRAME_W-1:0]  in_frame_index,
  input logic                          in_hate,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lhfr_pkg::STATUS_W-1:0] out_status,
  input logic [lhfr_pkg::FRAME_W-1:0]  out_victim_frame
);

  // a result with a nonzero status never names a frame
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != lhfr_pkg::ST_OK) |-> (out_victim_frame == '0))
    else $error("victim frame set with nonzero status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_victim_frame)))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  // a new result shows up exactly when the block turns ready again
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while still busy");

endmodule

bind love_hate_frame_replacer_core lhfr_checker u_lhfr_checker (.*);

@@ sim/lhfr_checker.sv @@
// result checker for the love/hate frame replacer: tracks the frame table and compares results
`timescale 1ns / 1ps

module lhfr_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lhfr_pkg::ACTION_W-1:0] in_action,
  input  logic [lhfr_pkg::FRAME_W-1:0]  in_frame_index,
  input  logic                          in_hate,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lhfr_pkg::STATUS_W-1:0] out_status,
  input  logic [lhfr_pkg::FRAME_W-1:0]  out_victim_frame,
  output int                            mismatch_count,
  output int                            results_owed
);

  // shadow of the recency list and the frame table
  logic [lhfr_pkg::IDX_W-1:0] lru_frame [lhfr_pkg::NUM_FRAMES];
  logic                       lru_live  [lhfr_pkg::NUM_FRAMES];
  logic [lhfr_pkg::PIN_W-1:0] pins      [lhfr_pkg::NUM_FRAMES];
  logic                       loved     [lhfr_pkg::NUM_FRAMES];

  logic [lhfr_pkg::STATUS_W-1:0] owed_status [$];
  logic [lhfr_pkg::FRAME_W-1:0]  owed_victim [$];
  int                            fails;
  int                            result_seq;

  function automatic void move_to_front(input logic [lhfr_pkg::IDX_W-1:0] f);
    int pos;
    pos = lhfr_pkg::NUM_FRAMES - 1;
    for (int k = 0; k < lhfr_pkg::NUM_FRAMES; k++) begin
      if (!lru_live[k] || lru_frame[k] == f) begin
        pos = k;
        break;
      end
    end
    for (int k = pos; k > 0; k--) begin
      lru_frame[k] = lru_frame[k-1];
      lru_live[k]  = lru_live[k-1];
    end
    lru_frame[0] = f;
    lru_live[0]  = 1'b1;
  endfunction

  function automatic void apply_frame_action(input logic [lhfr_pkg::ACTION_W-1:0] act,
                                             input logic [lhfr_pkg::FRAME_W-1:0] frame,
                                             input logic hate,
                                             output logic [lhfr_pkg::STATUS_W-1:0] status,
                                             output logic [lhfr_pkg::FRAME_W-1:0] victim);
    logic [lhfr_pkg::IDX_W-1:0] f;
    logic [lhfr_pkg::IDX_W-1:0] c;
    logic [lhfr_pkg::IDX_W-1:0] loved_pick;
    logic                       found_hated;
    logic                       found_loved;
    logic                       no_effect;
    status      = lhfr_pkg::ST_OK;
    victim      = '0;
    f           = lhfr_pkg::IDX_W'(frame);
    found_hated = 1'b0;
    found_loved = 1'b0;
    loved_pick  = '0;
    no_effect   = (act <= lhfr_pkg::ACT_FREE) && (int'(frame) >= lhfr_pkg::NUM_FRAMES);
    if (!no_effect) begin
      case (act)
        lhfr_pkg::ACT_PIN_HIT: begin
          if (int'(pins[f]) < lhfr_pkg::PIN_MAX) pins[f] = pins[f] + 1'b1;
          move_to_front(f);
        end
        lhfr_pkg::ACT_LOAD: begin
          pins[f]  = lhfr_pkg::PIN_W'(1);
          loved[f] = 1'b0;
          move_to_front(f);
        end
        lhfr_pkg::ACT_UNPIN: begin
          if (pins[f] == '0) begin
            status = lhfr_pkg::ST_UNPIN_UNPINNED;
          end else begin
            pins[f]  = pins[f] - 1'b1;
            loved[f] = loved[f] | ~hate;
          end
        end
        lhfr_pkg::ACT_FREE: begin
          if (pins[f] != '0) status = lhfr_pkg::ST_FREE_PINNED;
          else loved[f] = 1'b0;
        end
        lhfr_pkg::ACT_VICTIM: begin
          for (int k = 0; k < lhfr_pkg::NUM_FRAMES; k++) begin
            if (!lru_live[k]) break;
            c = lru_frame[k];
            if (int'(c) >= lhfr_pkg::NUM_FRAMES || pins[c] != '0) continue;
            if (!loved[c]) begin
              victim      = lhfr_pkg::FRAME_W'(c);
              found_hated = 1'b1;
              break;
            end
            loved_pick  = c;
            found_loved = 1'b1;
          end
          if (!found_hated) begin
            if (found_loved) begin
              victim = lhfr_pkg::FRAME_W'(loved_pick);
            end else begin
              status = lhfr_pkg::ST_NO_VICTIM;
              victim = '0;
            end
          end
        end
        lhfr_pkg::ACT_FLUSH_ALL: begin
          for (int k = 0; k < lhfr_pkg::NUM_FRAMES; k++) begin
            pins[k]  = '0;
            loved[k] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    logic [lhfr_pkg::STATUS_W-1:0] want_status;
    logic [lhfr_pkg::FRAME_W-1:0]  want_victim;
    if (!rst_n) begin
      for (int k = 0; k < lhfr_pkg::NUM_FRAMES; k++) begin
        lru_frame[k] = '0;
        lru_live[k]  = 1'b0;
        pins[k]      = '0;
        loved[k]     = 1'b0;
      end
      owed_status.delete();
      owed_victim.delete();
      fails      = 0;
      result_seq = 0;
    end else begin
      // results first, so a result can never meet its own transfer's expectation
      if (out_valid && !out_stall) begin
        if (owed_status.size() == 0) begin
          if (fails < 10)
            $display("%0t: result %0d arrived with nothing owed (status %0d victim %0d)",
                     $realtime, result_seq, out_status, out_victim_frame);
          fails++;
        end else begin
          want_status = owed_status.pop_front();
          want_victim = owed_victim.pop_front();
          if (out_status !== want_status || out_victim_frame !== want_victim) begin
            if (fails < 10)
              $display("%0t: result %0d: status exp %0d got %0d, victim exp %0d got %0d",
                       $realtime, result_seq, want_status, out_status,
                       want_victim, out_victim_frame);
            fails++;
          end
        end
        result_seq++;
      end
      if (in_valid && !in_stall) begin
        apply_frame_action(in_action, in_frame_index, in_hate, want_status, want_victim);
        owed_status.push_back(want_status);
        owed_victim.push_back(want_victim);
      end
    end
    mismatch_count <= fails;
    results_owed   <= owed_status.size();
  end

endmodule

@@ sim/love_hate_frame_replacer_core_tb.sv @@
// testbench top for the love/hate frame replacer: drives actions and gives the verdict
`timescale 1ns / 1ps

module love_hate_frame_replacer_core_tb;

  // action codes the block must ignore
  localparam logic [lhfr_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [lhfr_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  // this margin covers the tail of any list walk
  localparam int SETTLE_CYCLES = lhfr_pkg::NUM_FRAMES + 10;
  localparam int LONG_HOLD     = 400;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [lhfr_pkg::ACTION_W-1:0] in_action      = lhfr_pkg::ACT_VICTIM;
  logic [lhfr_pkg::FRAME_W-1:0]  in_frame_index = '0;
  logic                          in_hate        = 1'b0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic [lhfr_pkg::STATUS_W-1:0] out_status;
  logic [lhfr_pkg::FRAME_W-1:0]  out_victim_frame;

  int   mismatches;
  int   owed;

  // idle odds in percent, changed per phase
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // receiver hold-off: the stimulus raises the request, the receiver counts
  logic hold_request  = 1'b0;
  int   hold_left     = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  love_hate_frame_replacer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_frame_index   (in_frame_index),
    .in_hate          (in_hate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_victim_frame (out_victim_frame)
  );

  lhfr_scoreboard u_scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_frame_index   (in_frame_index),
    .in_hate          (in_hate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_victim_frame (out_victim_frame),
    .mismatch_count   (mismatches),
    .results_owed     (owed)
  );

  // receiver side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one transfer on the action channel, with random idle cycles ahead of it
  task automatic send_action(input logic [lhfr_pkg::ACTION_W-1:0] act,
                             input logic [lhfr_pkg::FRAME_W-1:0] frame,
                             input logic hate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_frame_index <= frame;
    in_hate        <= hate;
    @(posedge clk);
    // payload holds until the block takes it
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    // wait an edge so the checker's count includes the last transfer
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // buffer-pool traffic: unpins outweigh pin hits so frames keep becoming victims,
  // and half the actions hit a few hot frames so the recency list reorders
  task automatic send_pool_traffic(input int count);
    int                            sent;
    int                            pick;
    logic [lhfr_pkg::ACTION_W-1:0] act;
    logic [lhfr_pkg::FRAME_W-1:0]  frame;
    logic                          hate;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 20)      act = lhfr_pkg::ACT_PIN_HIT;
      else if (pick < 34) act = lhfr_pkg::ACT_LOAD;
      else if (pick < 60) act = lhfr_pkg::ACT_UNPIN;
      else if (pick < 70) act = lhfr_pkg::ACT_FREE;
      else if (pick < 92) act = lhfr_pkg::ACT_VICTIM;
      else if (pick < 95) act = lhfr_pkg::ACT_FLUSH_ALL;
      else if (pick < 98) act = ACT_SPARE_A;
      else                act = ACT_SPARE_B;
      if ($urandom_range(1) == 0) frame = lhfr_pkg::FRAME_W'($urandom_range(3));
      else                        frame = lhfr_pkg::FRAME_W'($urandom_range(15));
      hate = 1'($urandom_range(1));
      send_action(act, frame, hate);
      // ignored actions do not count as traffic
      if (act != ACT_SPARE_A && act != ACT_SPARE_B) sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender rarely idle, receiver often stalls
    send_idle_pct = 6;
    recv_idle_pct = 45;

    // directed opening on an empty pool
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);  // empty list, no victim
    send_action(lhfr_pkg::ACT_UNPIN,     4'd0,  1'b1);  // unpin of an unpinned frame
    send_action(lhfr_pkg::ACT_FREE,      4'd0,  1'b0);  // free of an unpinned frame
    send_action(lhfr_pkg::ACT_LOAD,      4'd0,  1'b1);  // hate ignored by load
    send_action(lhfr_pkg::ACT_LOAD,      4'd15, 1'b0);
    send_action(lhfr_pkg::ACT_PIN_HIT,   4'd7,  1'b1);  // pin hit inserts a new frame
    send_action(lhfr_pkg::ACT_PIN_HIT,   4'd15, 1'b0);  // moves to front, pin count two
    send_action(lhfr_pkg::ACT_FREE,      4'd15, 1'b0);  // free of a pinned frame
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);  // every listed frame pinned
    send_action(lhfr_pkg::ACT_UNPIN,     4'd0,  1'b1);  // hated
    send_action(lhfr_pkg::ACT_UNPIN,     4'd7,  1'b0);  // loved
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);  // hated frame wins over loved
    send_action(lhfr_pkg::ACT_FREE,      4'd0,  1'b0);
    send_action(lhfr_pkg::ACT_UNPIN,     4'd0,  1'b0);  // already unpinned
    send_action(lhfr_pkg::ACT_PIN_HIT,   4'd0,  1'b0);
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);  // only a loved frame left
    send_action(lhfr_pkg::ACT_UNPIN,     4'd15, 1'b1);
    send_action(lhfr_pkg::ACT_UNPIN,     4'd15, 1'b0);  // loved once the count hits zero
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);  // least recent loved frame
    send_action(ACT_SPARE_A,             4'd15, 1'b1);  // unknown actions change nothing
    send_action(ACT_SPARE_B,             4'd0,  1'b0);
    send_action(lhfr_pkg::ACT_FLUSH_ALL, 4'd3,  1'b1);  // frame and hate ignored
    send_action(lhfr_pkg::ACT_VICTIM,    4'd9,  1'b1);  // all frames hated, most recent first
    send_action(lhfr_pkg::ACT_LOAD,      4'd15, 1'b1);
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0,  1'b0);

    send_pool_traffic(40);

    // long receiver hold-off while the sender keeps offering transfers
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    send_pool_traffic(12);
    send_pool_traffic(30);

    // phase two: sender often idle, receiver rarely stalls
    drain_results();
    send_idle_pct = 45;
    recv_idle_pct = 6;
    send_pool_traffic(40);
    // sender pauses until the pool is quiet
    drain_results();
    send_pool_traffic(40);

    // phase three: no idling on either side
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pool_traffic(40);

    // pin count saturates at its ceiling and then steps back down
    repeat (lhfr_pkg::PIN_MAX + 3) send_action(lhfr_pkg::ACT_PIN_HIT, 4'd9, 1'b0);
    send_action(lhfr_pkg::ACT_UNPIN,     4'd9, 1'b0);
    send_action(lhfr_pkg::ACT_UNPIN,     4'd9, 1'b1);
    send_action(lhfr_pkg::ACT_FREE,      4'd9, 1'b0);
    send_action(lhfr_pkg::ACT_VICTIM,    4'd0, 1'b0);
    send_action(lhfr_pkg::ACT_FLUSH_ALL, 4'd0, 1'b0);
    send_pool_traffic(40);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
